@@ hdl/ikcst_pkg.sv @@
// Package for the integer-keyed chained scatter table.
// Types, codes and default sizes shared by the controller, datapath and top level.
package ikcst_pkg;

  localparam int unsigned ARRAY_DEPTH = 64;
  localparam int unsigned LOG_NODES   = 6;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned CFG_DATA_W  = 7;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARRAY_EN  = 2'd0,
    CFG_DICT_EN   = 2'd1,
    CFG_ARRAY_SZ  = 2'd2,
    CFG_DICT_LOG2 = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_FULL     = 3'd4,
    ST_NONE     = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ARR_WR,
    OP_ARR_RES,
    OP_FIND_RD,
    OP_FIND_STEP,
    OP_VAL_RD,
    OP_VAL_RES,
    OP_VAL_WR,
    OP_PUT_MP,
    OP_FREE_STEP,
    OP_MP_RD,
    OP_MP_LAT,
    OP_WALK_RD,
    OP_WALK_STEP,
    OP_LINK_OTHER
  } dp_op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_MOVE,
    WR_FIN_MOVE,
    WR_LINK_FREE,
    WR_FIN_FREE,
    WR_EMIT
  } dp_wr_e;

  typedef struct packed {
    dp_op_e  op;
    dp_wr_e  wr;
    logic    st_en;
    status_e st;
  } cmd_t;

  typedef struct packed {
    logic both_off;
    logic is_arr;
    logic dict_off;
    logic is_set;
    logic hit;
    logic chain_end;
    logic mp_used;
    logic fsp_zero;
    logic dec_free;
    logic oth_eq;
    logic walk_done;
    logic out_free;
  } flags_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_ARR_RES,
    S_FIND_RD,
    S_FIND_CHK,
    S_VAL_RD,
    S_VAL_RES,
    S_INS,
    S_FREE,
    S_MP_RD,
    S_MP_LAT,
    S_WALK_RD,
    S_WALK_CHK,
    S_LINK_OTHER,
    S_MOVE,
    S_FIN_MOVE,
    S_LINK_FREE,
    S_FIN_FREE,
    S_DONE
  } ctl_state_e;

endpackage

@@ hdl/ikcst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ikcst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ikcst_ctrl.sv @@
// Sequencer for the scatter table: walks chains, scans for free nodes, orders writes.
// Depends on ikcst_pkg; drives the datapath by command, reads its flags.
module ikcst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ikcst_pkg::flags_t flags_i,
  output ikcst_pkg::cmd_t   cmd_o
);
  import ikcst_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: OP_NONE, wr: WR_NONE, st_en: 1'b0, st: ST_HIT};
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (flags_i.both_off) begin
          cmd_o.st_en = 1'b1;
          cmd_o.st    = ST_NONE;
          state_d     = S_DONE;
        end else if (flags_i.is_arr) begin
          if (flags_i.is_set) begin
            cmd_o.op    = OP_ARR_WR;
            cmd_o.st_en = 1'b1;
            cmd_o.st    = ST_UPDATED;
            state_d     = S_DONE;
          end else begin
            state_d = S_ARR_RES;
          end
        end else if (flags_i.dict_off) begin
          cmd_o.st_en = 1'b1;
          cmd_o.st    = flags_i.is_set ? ST_NONE : ST_MISS;
          state_d     = S_DONE;
        end else begin
          state_d = S_FIND_RD;
        end
      end
      S_ARR_RES: begin
        cmd_o.op    = OP_ARR_RES;
        cmd_o.st_en = 1'b1;
        cmd_o.st    = ST_HIT;
        state_d     = S_DONE;
      end
      S_FIND_RD: begin
        cmd_o.op = OP_FIND_RD;
        state_d  = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (flags_i.hit) begin
          if (flags_i.is_set) begin
            cmd_o.op    = OP_VAL_WR;
            cmd_o.st_en = 1'b1;
            cmd_o.st    = ST_UPDATED;
            state_d     = S_DONE;
          end else begin
            state_d = S_VAL_RD;
          end
        end else if (flags_i.chain_end) begin
          if (flags_i.is_set) begin
            state_d = S_INS;
          end else begin
            cmd_o.st_en = 1'b1;
            cmd_o.st    = ST_MISS;
            state_d     = S_DONE;
          end
        end else begin
          cmd_o.op = OP_FIND_STEP;
          state_d  = S_FIND_RD;
        end
      end
      S_VAL_RD: begin
        cmd_o.op = OP_VAL_RD;
        state_d  = S_VAL_RES;
      end
      S_VAL_RES: begin
        cmd_o.op    = OP_VAL_RES;
        cmd_o.st_en = 1'b1;
        cmd_o.st    = ST_HIT;
        state_d     = S_DONE;
      end
      S_INS: begin
        if (flags_i.mp_used) begin
          state_d = S_FREE;
        end else begin
          cmd_o.op    = OP_PUT_MP;
          cmd_o.st_en = 1'b1;
          cmd_o.st    = ST_INSERTED;
          state_d     = S_DONE;
        end
      end
      S_FREE: begin
        if (flags_i.fsp_zero) begin
          cmd_o.st_en = 1'b1;
          cmd_o.st    = ST_FULL;
          state_d     = S_DONE;
        end else begin
          cmd_o.op = OP_FREE_STEP;
          if (flags_i.dec_free) begin
            state_d = S_MP_RD;
          end
        end
      end
      S_MP_RD: begin
        cmd_o.op = OP_MP_RD;
        state_d  = S_MP_LAT;
      end
      S_MP_LAT: begin
        cmd_o.op = OP_MP_LAT;
        state_d  = flags_i.oth_eq ? S_LINK_FREE : S_WALK_RD;
      end
      S_WALK_RD: begin
        cmd_o.op = OP_WALK_RD;
        state_d  = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        cmd_o.op = OP_WALK_STEP;
        state_d  = flags_i.walk_done ? S_LINK_OTHER : S_WALK_RD;
      end
      S_LINK_OTHER: begin
        cmd_o.op = OP_LINK_OTHER;
        state_d  = S_MOVE;
      end
      S_MOVE: begin
        cmd_o.wr = WR_MOVE;
        state_d  = S_FIN_MOVE;
      end
      S_FIN_MOVE: begin
        cmd_o.wr    = WR_FIN_MOVE;
        cmd_o.st_en = 1'b1;
        cmd_o.st    = ST_INSERTED;
        state_d     = S_DONE;
      end
      S_LINK_FREE: begin
        cmd_o.wr = WR_LINK_FREE;
        state_d  = S_FIN_FREE;
      end
      S_FIN_FREE: begin
        cmd_o.wr    = WR_FIN_FREE;
        cmd_o.st_en = 1'b1;
        cmd_o.st    = ST_INSERTED;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (flags_i.out_free) begin
          cmd_o.wr = WR_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ hdl/ikcst_dp.sv @@
// Datapath of the scatter table: config registers, array and node stores, output register.
// Depends on ikcst_pkg and ikcst_ram; steered by ikcst_ctrl commands.
module ikcst_dp #(
  parameter int unsigned ARRAY_DEPTH = ikcst_pkg::ARRAY_DEPTH,
  parameter int unsigned LOG_NODES   = ikcst_pkg::LOG_NODES,
  parameter int unsigned VALUE_WIDTH = ikcst_pkg::VALUE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ikcst_pkg::cmd_t                  cmd_i,
  output ikcst_pkg::flags_t                flags_o,
  input  logic                             in_action_i,
  input  logic [ikcst_pkg::KEY_W-1:0]      in_key_i,
  input  logic [31:0]                      in_wval_i,
  input  logic                             cfg_valid_i,
  input  logic [ikcst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ikcst_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       out_status_o,
  output logic [31:0]                      out_rval_o,
  output logic                             out_in_array_o
);
  import ikcst_pkg::*;

  localparam int unsigned NODES = 1 << LOG_NODES;
  localparam int unsigned LN    = LOG_NODES;
  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned AIW   = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam logic [3:0]  LN4   = 4'(LOG_NODES);
  localparam int unsigned RST_EFF = (LOG_NODES < 6) ? LOG_NODES : 6;
  localparam logic [31:0] AD32  = 32'(ARRAY_DEPTH);

  // config
  logic          arr_en_q, dict_en_q;
  logic [6:0]    arr_sz_q;
  logic [2:0]    dlog_q;

  // control state
  logic [NODES-1:0]       used_q, nvld_q;
  logic [ARRAY_DEPTH-1:0] avld_q;
  logic [LN:0]            fsp_q;
  logic                   oval_q;

  // payload
  logic            act_q, inarr_q;
  logic [31:0]     key_q, kmp_q;
  logic [VW-1:0]   wv_q, vmp_q, rv_q;
  logic [LN-1:0]   idx_q, steps_q, fr_q, oth_q, nmp_q, raddr_q;
  status_e         st_q;
  logic [2:0]      ost_q;
  logic [31:0]     orv_q;
  logic            oarr_q;

  // comb
  logic [3:0]    eff, eff_new;
  logic [LN-1:0] mask, mp, raddr, nxt_rd, step_idx, nx, fsp_lo;
  logic [LN:0]   fsp_dec;
  logic [31:0]   asz, key_rd;
  logic [VW-1:0] val_rd, arr_rd, wv_in;
  logic          key_in_arr;
  logic [LN-1:0] n_rdata;

  logic            k_we, v_we, n_we;
  logic [LN-1:0]   k_wa, v_wa, n_wa;
  logic [31:0]     k_wd;
  logic [VW-1:0]   v_wd;
  logic [LN-1:0]   n_wd, link_mv;

  assign eff     = ({1'b0, dlog_q} > LN4) ? LN4 : {1'b0, dlog_q};
  assign eff_new = ({1'b0, cfg_data_i[2:0]} > LN4) ? LN4 : {1'b0, cfg_data_i[2:0]};
  assign mask    = ~({LN{1'b1}} << eff);
  assign mp      = key_q[LN-1:0] & mask;
  assign asz     = ({25'd0, arr_sz_q} > AD32) ? AD32 : {25'd0, arr_sz_q};
  assign key_in_arr = arr_en_q && (in_key_i < asz);
  assign wv_in   = VW'({32'd0, in_wval_i});

  assign nxt_rd   = nvld_q[raddr_q] ? n_rdata : '0;
  assign step_idx = (idx_q + nxt_rd) & mask;
  assign nx       = (oth_q + nxt_rd) & mask;
  assign fsp_dec  = fsp_q - 1'b1;
  assign fsp_lo   = fsp_dec[LN-1:0];
  assign link_mv  = (nmp_q != '0) ? ((nmp_q + mp - fr_q) & mask) : '0;

  always_comb begin
    case (cmd_i.op)
      OP_MP_RD:   raddr = mp;
      OP_WALK_RD: raddr = oth_q;
      default:    raddr = idx_q;
    endcase
  end

  // node store write ports
  always_comb begin
    k_we = 1'b0; k_wa = mp; k_wd = key_q;
    v_we = 1'b0; v_wa = mp; v_wd = wv_q;
    n_we = 1'b0; n_wa = mp; n_wd = '0;
    case (cmd_i.op)
      OP_VAL_WR: begin
        v_we = 1'b1; v_wa = idx_q;
      end
      OP_PUT_MP: begin
        k_we = 1'b1; v_we = 1'b1;
      end
      OP_LINK_OTHER: begin
        n_we = 1'b1; n_wa = oth_q; n_wd = (fr_q - oth_q) & mask;
      end
      default: ;
    endcase
    case (cmd_i.wr)
      WR_MOVE: begin
        k_we = 1'b1; k_wa = fr_q; k_wd = kmp_q;
        v_we = 1'b1; v_wa = fr_q; v_wd = vmp_q;
        n_we = 1'b1; n_wa = fr_q; n_wd = link_mv;
      end
      WR_FIN_MOVE: begin
        k_we = 1'b1; v_we = 1'b1; n_we = 1'b1;
      end
      WR_LINK_FREE: begin
        n_we = 1'b1; n_wa = fr_q; n_wd = link_mv;
      end
      WR_FIN_FREE: begin
        n_we = 1'b1; n_wd = (fr_q - mp) & mask;
        k_we = 1'b1; k_wa = fr_q;
        v_we = 1'b1; v_wa = fr_q;
      end
      default: ;
    endcase
  end

  ikcst_ram #(.WIDTH(32), .DEPTH(NODES)) u_keys (
    .clk_i, .we_i(k_we), .waddr_i(k_wa), .wdata_i(k_wd), .raddr_i(raddr), .rdata_o(key_rd)
  );
  ikcst_ram #(.WIDTH(VW), .DEPTH(NODES)) u_vals (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd), .raddr_i(raddr), .rdata_o(val_rd)
  );
  ikcst_ram #(.WIDTH(LN), .DEPTH(NODES)) u_next (
    .clk_i, .we_i(n_we), .waddr_i(n_wa), .wdata_i(n_wd), .raddr_i(raddr), .rdata_o(n_rdata)
  );
  ikcst_ram #(.WIDTH(VW), .DEPTH(ARRAY_DEPTH)) u_arr (
    .clk_i, .we_i(cmd_i.op == OP_ARR_WR), .waddr_i(key_q[AIW-1:0]), .wdata_i(wv_q),
    .raddr_i(key_q[AIW-1:0]), .rdata_o(arr_rd)
  );

  // flags
  always_comb begin
    flags_o.both_off  = !arr_en_q && !dict_en_q;
    flags_o.is_arr    = inarr_q;
    flags_o.dict_off  = !dict_en_q;
    flags_o.is_set    = act_q;
    flags_o.hit       = used_q[idx_q] && (key_rd == key_q);
    flags_o.chain_end = (nxt_rd == '0) || (steps_q == mask);
    flags_o.mp_used   = used_q[mp];
    flags_o.fsp_zero  = (fsp_q == '0);
    flags_o.dec_free  = !used_q[fsp_lo];
    flags_o.oth_eq    = ((key_rd[LN-1:0] & mask) == mp);
    flags_o.walk_done = (nx == mp) || (nxt_rd == '0) || (steps_q == mask);
    flags_o.out_free  = !oval_q || out_ready_i;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arr_en_q  <= 1'b1;
      dict_en_q <= 1'b1;
      arr_sz_q  <= '0;
      dlog_q    <= 3'd6;
      used_q    <= '0;
      nvld_q    <= '0;
      avld_q    <= '0;
      fsp_q     <= (LN+1)'(1) << RST_EFF;
      oval_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_ARRAY_EN:  arr_en_q  <= cfg_data_i[0];
          CFG_DICT_EN:   dict_en_q <= cfg_data_i[0];
          CFG_ARRAY_SZ:  arr_sz_q  <= cfg_data_i;
          CFG_DICT_LOG2: begin
            dlog_q <= cfg_data_i[2:0];
            used_q <= '0;
            nvld_q <= '0;
            fsp_q  <= (LN+1)'(1) << eff_new;
          end
          default: ;
        endcase
      end
      if (cmd_i.op == OP_ARR_WR) begin
        avld_q[key_q[AIW-1:0]] <= 1'b1;
      end
      if (cmd_i.op == OP_FREE_STEP) begin
        fsp_q <= fsp_dec;
      end
      if (k_we) begin
        used_q[k_wa] <= 1'b1;
      end
      if (n_we) begin
        nvld_q[n_wa] <= 1'b1;
      end
      if (cmd_i.wr == WR_EMIT) begin
        oval_q <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    raddr_q <= raddr;
    case (cmd_i.op)
      OP_LOAD: begin
        act_q   <= in_action_i;
        key_q   <= in_key_i;
        wv_q    <= wv_in;
        inarr_q <= key_in_arr;
        idx_q   <= in_key_i[LN-1:0] & mask;
        steps_q <= '0;
        rv_q    <= '0;
      end
      OP_ARR_RES: rv_q <= avld_q[key_q[AIW-1:0]] ? arr_rd : '0;
      OP_VAL_RES: rv_q <= val_rd;
      OP_FIND_STEP: begin
        idx_q   <= step_idx;
        steps_q <= steps_q + 1'b1;
      end
      OP_FREE_STEP: fr_q <= fsp_lo;
      OP_MP_LAT: begin
        kmp_q   <= key_rd;
        vmp_q   <= val_rd;
        nmp_q   <= nxt_rd;
        oth_q   <= key_rd[LN-1:0] & mask;
        steps_q <= '0;
      end
      OP_WALK_STEP: begin
        if (!((nx == mp) || (nxt_rd == '0))) begin
          oth_q <= nx;
        end
        steps_q <= steps_q + 1'b1;
      end
      default: ;
    endcase
    if (cmd_i.st_en) begin
      st_q <= cmd_i.st;
    end
    if (cmd_i.wr == WR_EMIT) begin
      ost_q  <= st_q;
      orv_q  <= 32'({64'd0, rv_q});
      oarr_q <= inarr_q;
    end
  end

  assign out_valid_o    = oval_q;
  assign out_status_o   = ost_q;
  assign out_rval_o     = orv_q;
  assign out_in_array_o = oarr_q;

endmodule

@@ hdl/int_key_chained_scatter_table_unit.sv @@
// Top level of the integer-keyed chained scatter table.
// Depends on ikcst_pkg, ikcst_ctrl, ikcst_dp (which holds the ikcst_ram stores).
//
// Usage
//   Request beats come in on s_axis: tuser carries the action (0 get, 1 set),
//   tdata the key (bits 31:0, unsigned) and the write value (bits 63:32).
//   One response beat per request leaves on m_axis: tdata is the read value,
//   tuser holds status (bits 2:0) and the array-part flag (bit 3).
//   Registers are written over the cfg channel (index, data); it is always
//   ready and must only be used while the table is idle. Writing dict_log2
//   empties the node store at once.
// Timing
//   One request is worked on at a time. Array sets and disabled parts are
//   quickest, an array get adds S_ARR_RES, and a set that has to move a
//   colliding node is slowest: it walks the chain, scans for a free node and
//   walks the squatter's chain. The next request beat is taken in the cycle
//   after the response is registered. Access time is set by the single read
//   port of each node store: every chain step passes an address state and a
//   compare state, every free-scan step is one pass through S_FREE.
// Reset and stalls
//   Reset empties the array part (reads zero), the node store and the output
//   register; config returns to both parts on, array size 0, dict_log2 6.
//   A stalled receiver holds the response in the output register; the next
//   request is still accepted and runs until its own response is ready.
module int_key_chained_scatter_table_unit #(
  parameter int unsigned ARRAY_DEPTH = ikcst_pkg::ARRAY_DEPTH,
  parameter int unsigned LOG_NODES   = ikcst_pkg::LOG_NODES,
  parameter int unsigned VALUE_WIDTH = ikcst_pkg::VALUE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [63:0]                      s_axis_tdata,  // key[31:0], write_value[63:32]
  input  logic [0:0]                       s_axis_tuser,  // action
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [31:0]                      m_axis_tdata,  // read_value
  output logic [3:0]                       m_axis_tuser,  // status[2:0], in_array[3]
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ikcst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ikcst_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ikcst_pkg::*;

  cmd_t   cmd;
  flags_t flags;
  logic [2:0] st;
  logic       in_arr;

  // config writes are registered directly, never stalled
  assign cfg_ready_o = 1'b1;

  ikcst_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  ikcst_dp #(
    .ARRAY_DEPTH (ARRAY_DEPTH),
    .LOG_NODES   (LOG_NODES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i          (cmd),
    .flags_o        (flags),
    .in_action_i    (s_axis_tuser[0]),
    .in_key_i       (s_axis_tdata[31:0]),
    .in_wval_i      (s_axis_tdata[63:32]),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_status_o   (st),
    .out_rval_o     (m_axis_tdata),
    .out_in_array_o (in_arr)
  );

  assign m_axis_tuser = {in_arr, st};

endmodule

@@ sim/ikcst_checker.sv @@
// Checker for the chained scatter table: mirrors the config, predicts each response.
// Depends on ikcst_pkg; watches the s_axis, m_axis and cfg channels of the unit.
module ikcst_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [3:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          responses_o
);
  import ikcst_pkg::*;

  typedef struct packed {
    status_e     st;
    logic [31:0] rv;
    logic        in_arr;
  } resp_t;

  resp_t       resp_q[$];
  logic [31:0] arr_mem[64];
  logic        nd_used[64];
  logic [31:0] nd_key[64];
  logic [31:0] nd_val[64];
  logic [7:0]  nd_next[64];
  int          free_ptr;
  logic        arr_on, dict_on;
  logic [6:0]  arr_size;
  logic [2:0]  dict_lg;

  assign pending_o = resp_q.size();

  function automatic int node_mask();
    return (1 << ((dict_lg > 6) ? 6 : dict_lg)) - 1;
  endfunction

  task automatic wipe_nodes();
    for (int i = 0; i < 64; i++) begin
      nd_used[i] = 1'b0;
      nd_next[i] = '0;
    end
    free_ptr = node_mask() + 1;
  endtask

  task automatic table_access(input logic is_set, input logic [31:0] key,
                              input logic [31:0] wv, output resp_t r);
    int m, i, n, mp, fr, oth, nx, asz;
    m = node_mask();
    asz = (arr_size > 64) ? 64 : arr_size;
    r = '{ST_NONE, 32'd0, 1'b0};
    n = -1;
    if (!arr_on && !dict_on) begin
      r.st = ST_NONE;
    end else if (arr_on && key < asz) begin
      r.in_arr = 1'b1;
      if (is_set) begin
        arr_mem[key] = wv;
        r.st = ST_UPDATED;
      end else begin
        r.rv = arr_mem[key];
        r.st = ST_HIT;
      end
    end else if (!dict_on) begin
      r.st = is_set ? ST_NONE : ST_MISS;
    end else begin
      // chain walk, bounded by node count
      i = key & m;
      for (int s = 0; s <= m; s++) begin
        if (nd_used[i] && nd_key[i] == key) begin
          n = i;
          break;
        end
        if (nd_next[i] == 0) break;
        i = (i + nd_next[i]) & m;
      end
      if (!is_set) begin
        if (n >= 0) begin
          r.rv = nd_val[n];
          r.st = ST_HIT;
        end else r.st = ST_MISS;
      end else if (n >= 0) begin
        nd_val[n] = wv;
        r.st = ST_UPDATED;
      end else begin
        mp = key & m;
        n = -1;
        if (!nd_used[mp]) n = mp;
        else begin
          fr = -1;
          while (free_ptr > 0) begin
            free_ptr--;
            if (free_ptr < 64 && !nd_used[free_ptr]) begin
              fr = free_ptr;
              break;
            end
          end
          if (fr >= 0) begin
            oth = nd_key[mp] & m;
            if (oth != mp) begin
              // squatter: find its predecessor, relocate it to the free node
              for (int s = 0; s <= m; s++) begin
                nx = (oth + nd_next[oth]) & m;
                if (nx == mp || nd_next[oth] == 0) break;
                oth = nx;
              end
              nd_next[oth] = 8'((fr - oth) & m);
              nd_used[fr]  = 1'b1;
              nd_key[fr]   = nd_key[mp];
              nd_val[fr]   = nd_val[mp];
              nd_next[fr]  = (nd_next[mp] != 0) ? 8'((nd_next[mp] + mp - fr) & m) : '0;
              nd_next[mp]  = '0;
              nd_val[mp]   = '0;
              n = mp;
            end else begin
              nd_next[fr] = (nd_next[mp] != 0) ? 8'((mp + nd_next[mp] - fr) & m) : '0;
              nd_next[mp] = 8'((fr - mp) & m);
              n = fr;
            end
          end
        end
        if (n < 0) r.st = ST_FULL;
        else begin
          nd_used[n] = 1'b1;
          nd_key[n]  = key;
          nd_val[n]  = wv;
          r.st = ST_INSERTED;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    resp_t r, got;
    if (!rst_ni) begin
      resp_q.delete();
      errors_o    <= 0;
      responses_o <= 0;
      arr_on = 1'b1;
      dict_on = 1'b1;
      arr_size = '0;
      dict_lg = 3'd6;
      for (int i = 0; i < 64; i++) arr_mem[i] = '0;
      wipe_nodes();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ARRAY_EN: arr_on = cfg_data_i[0];
          CFG_DICT_EN: dict_on = cfg_data_i[0];
          CFG_ARRAY_SZ: arr_size = cfg_data_i;
          CFG_DICT_LOG2: begin
            dict_lg = cfg_data_i[2:0];
            wipe_nodes();
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        table_access(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32], r);
        resp_q.push_back(r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{status_e'(m_axis_tuser[2:0]), m_axis_tdata, m_axis_tuser[3]};
        responses_o <= responses_o + 1;
        if (resp_q.size() == 0) begin
          $display("%0t: unexpected response beat, got st=%0d rv=%h arr=%b",
                   $time, got.st, got.rv, got.in_arr);
          errors_o <= errors_o + 1;
        end else begin
          r = resp_q.pop_front();
          if (got !== r) begin
            $display("%0t: mismatch, expected st=%0d rv=%h arr=%b, got st=%0d rv=%h arr=%b",
                     $time, r.st, r.rv, r.in_arr, got.st, got.rv, got.in_arr);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the chained scatter table: clock, reset, stimulus and verdict.
// Depends on ikcst_pkg, the unit int_key_chained_scatter_table_unit and ikcst_checker.
module tb_top;
  import ikcst_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // key[31:0], write_value[63:32]
  logic [0:0]  s_axis_tuser = '0;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // read_value
  logic [3:0]  m_axis_tuser;        // status[2:0], in_array[3]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [6:0]  cfg_data_i = '0;

  int          errors, pending, responses;
  int          beats_sent = 0;
  int          cfg_writes = 0;
  bit          quiet = 1'b0;      // no idling on either side
  bit          hold_req = 1'b0;   // ask the receiver for one long stall
  logic [31:0] key_pool[$];

  localparam logic GET = 1'b0;
  localparam logic SET = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int_key_chained_scatter_table_unit u_dut (.*);

  ikcst_checker u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .responses_o(responses)
  );

  // generous watchdog, far beyond the slowest legal run
  initial begin
    #15_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver: random back-pressure bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic cfg_write(input cfg_idx_e idx, input logic [6:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_writes++;
  endtask

  // table must be drained before any register write
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic setup(input logic ae, input logic de, input logic [6:0] asz,
                       input logic [2:0] lg);
    drain();
    cfg_write(CFG_ARRAY_EN, {6'd0, ae});
    cfg_write(CFG_DICT_EN, {6'd0, de});
    cfg_write(CFG_ARRAY_SZ, asz);
    cfg_write(CFG_DICT_LOG2, {4'd0, lg});
    key_pool.delete();
  endtask

  task automatic send(input logic act, input logic [31:0] key, input logic [31:0] wv);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {wv, key};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    if (act == SET && key_pool.size() < 64) key_pool.push_back(key);
  endtask

  // mostly chain-building sets and gets of known keys, some raw noise
  task automatic random_item(input int unsigned lg, input int unsigned asz);
    logic [31:0] key;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4)
      key = $urandom_range(0, 7) + ($urandom_range(0, 5) << ((lg > 6) ? 6 : lg));
    else if (sel < 5)
      key = $urandom_range(0, (asz > 64) ? 64 : asz + 1);
    else if (sel < 8 && key_pool.size() > 0)
      key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else
      key = $urandom();
    if (sel == 9 && $urandom_range(0, 1)) key[31] = 1'b1;
    send(($urandom_range(0, 9) < 6) ? SET : GET, key, $urandom());
  endtask

  initial begin
    logic [6:0] asz;
    logic [2:0] lg;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset config, all keys hashed into 64 nodes
    send(GET, 32'd0, 32'd0);
    send(SET, 32'd0, 32'hFFFF_FFFF);
    send(SET, 32'd64, 32'h1111_1111);     // collides at node 0, chained
    send(SET, 32'd63, 32'h2222_2222);     // main position held by a squatter: moved
    send(GET, 32'd64, 32'd0);
    send(GET, 32'd0, 32'd0);
    send(SET, 32'hFFFF_FFFF, 32'h3);      // all-ones key
    send(SET, 32'h7FFF_FFFF, 32'h4);
    send(SET, 32'h8000_0000, 32'h5);
    send(GET, 32'h8000_0000, 32'd0);
    send(SET, 32'h7FFF_FFFF, 32'h0);      // update in place
    send(GET, 32'h7FFF_FFFF, 32'd0);
    // array part, oversize array setting acts as full depth
    setup(1'b1, 1'b1, 7'd127, 3'd7);
    send(GET, 32'd63, 32'd0);
    send(SET, 32'd63, 32'hA5A5_5A5A);
    send(GET, 32'd63, 32'd0);
    send(SET, 32'd64, 32'd9);             // just past the array: node part
    // single node store runs full
    setup(1'b1, 1'b1, 7'd0, 3'd0);
    send(SET, 32'd5, 32'd1);
    send(SET, 32'd6, 32'd2);
    send(GET, 32'd5, 32'd0);
    // node part off, then both off
    setup(1'b1, 1'b0, 7'd4, 3'd1);
    send(GET, 32'd9, 32'd0);
    send(SET, 32'd9, 32'd0);
    send(SET, 32'd2, 32'd7);
    setup(1'b0, 1'b0, 7'd4, 3'd1);
    send(GET, 32'd2, 32'd0);
    send(SET, 32'd2, 32'd0);

    // random phases over a spread of settings, extremes included
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin asz = 7'd0;  lg = 3'd6; end
        1: begin asz = 7'd64; lg = 3'd1; end
        2: begin asz = 7'd1;  lg = 3'd2; end
        3: begin asz = 7'd127; lg = 3'd7; end
        default: begin
          asz = 7'($urandom_range(0, 127));
          lg = 3'($urandom_range(0, 7));
        end
      endcase
      setup((p % 5 == 4) ? 1'($urandom_range(0, 1)) : 1'b1,
            (p % 5 == 3) ? 1'($urandom_range(0, 1)) : 1'b1, asz, lg);
      if (p == 9) quiet = 1'b1;
      for (int k = 0; k < 43; k++) begin
        if (p == 5 && k == 10) hold_req = 1'b1;
        random_item(lg, asz);
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("Sent %0d request beats, checked %0d responses, %0d register writes.",
             beats_sent, responses, cfg_writes);
    $display("Covered array and node parts, collisions, relocations, full and disabled parts.");
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
